[sv/lns_pkg.sv]
package lns_pkg;

	localparam int THUMB_SIZE  = 512;
	localparam int COORD_W     = $clog2(THUMB_SIZE);
	localparam int FIT_W       = $clog2(THUMB_SIZE) + 1;
	localparam int OFF_W       = COORD_W;
	localparam int SRC_DEPTH   = 65536;
	localparam int ADDR_W      = $clog2(SRC_DEPTH);
	localparam int MAX_SRC_DIM = 4096;
	localparam int DIM_W       = 13;
	localparam int PIX_W       = 32;
	localparam int FULL_ADDR_W = 2 * DIM_W + 1;

	localparam int DIV_N_W   = 24;
	localparam int DIV_D_W   = DIM_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	localparam logic [7:0] BG_RED   = 8'd42;
	localparam logic [7:0] BG_GREEN = 8'd45;
	localparam logic [7:0] BG_BLUE  = 8'd50;
	localparam logic [7:0] BG_ALPHA = 8'd255;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'd1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] src_index;
		logic [7:0]  pix_red;
		logic [7:0]  pix_green;
		logic [7:0]  pix_blue;
		logic [7:0]  pix_alpha;
		logic [8:0]  out_col;
		logic [8:0]  out_row;
	} lns_in_t;

	typedef struct packed {
		logic [7:0] thumb_red;
		logic [7:0] thumb_green;
		logic [7:0] thumb_blue;
		logic [7:0] thumb_alpha;
		logic       in_image;
	} lns_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIT_DIV,
		S_FIT_END,
		S_X_SET,
		S_X_DIV,
		S_Y_SET,
		S_Y_DIV,
		S_ADDR,
		S_READ,
		S_OUT
	} lns_state_t;

	function automatic logic [DIM_W-1:0] clean_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_SRC_DIM))
			r = DIM_W'(MAX_SRC_DIM);
		return r;
	endfunction

endpackage

[sv/lns_in_if.sv]
interface lns_in_if;
	import lns_pkg::*;
	logic    valid;
	logic    ready;
	lns_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/lns_out_if.sv]
interface lns_out_if;
	import lns_pkg::*;
	logic     valid;
	logic     ready;
	lns_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/letterbox_nearest_scaler.sv]
// Letterbox nearest-neighbour scaler. Load beats (req_type 0) write one RGBA
// pixel into a 64K x 32 source memory and give no result. Read beats
// (req_type 1) give one 512x512 thumbnail pixel: outside the fitted picture
// the background colour with in_image 0, inside it the nearest source pixel.
// A read inside the picture runs two 24-step bit-serial divisions (column and
// row) on one shared divider, each after its own setup state, then an address
// multiply, the registered memory read and the output register; no new beat
// is accepted until its result is loaded. A background read goes straight to
// the output register. A stalled result holds the block until it is taken.
// After reset and after every src_width or src_height write the fit is worked
// out again on the same divider, during which no beat is accepted. The source
// memory is not cleared; read only what was loaded.
module letterbox_nearest_scaler (
	input  logic                           clk,
	input  logic                           arst_n,
	lns_in_if.sink                         req,
	lns_out_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [lns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lns_pkg::DIM_W-1:0]      cfg_data
);
	import lns_pkg::*;

	lns_state_t state_q, state_d;

	logic [DIM_W-1:0] src_width_q, src_height_q;
	logic             refit_q;
	logic [FIT_W-1:0] fit_width_q, fit_height_q;
	logic [OFF_W-1:0] offset_x_q, offset_y_q;

	logic [PIX_W-1:0] mem_q [SRC_DEPTH];
	logic [PIX_W-1:0] rd_data_s;

	logic [DIV_N_W-1:0]   div_num_q, div_num_d;
	logic [DIV_D_W-1:0]   div_den_q, div_den_d, div_rem_q;
	logic [DIV_N_W-1:0]   div_quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 div_load;
	logic [DIV_D_W:0]     div_shift;
	logic                 div_ge;

	logic [COORD_W-1:0]     dx_q, dy_q;
	logic [DIM_W-1:0]       sx_q;
	logic [FULL_ADDR_W-1:0] addr_s;
	logic                   bg_q, oob_q;

	logic             out_valid_q;
	lns_out_t         out_q;

	logic [DIM_W-1:0] w_c, h_c;
	logic             wide;
	logic             in_fire, rd_fire;
	logic             frame_in;
	logic [FIT_W:0]   end_x, end_y;
	logic [FIT_W-1:0] short_c;
	logic [DIM_W-1:0] samp_c;
	logic [DIM_W-1:0] samp_dim;
	logic             out_load;

	assign w_c  = clean_dim(src_width_q);
	assign h_c  = clean_dim(src_height_q);
	assign wide = (w_c >= h_c);

	assign req.ready = (state_q == S_IDLE) && !refit_q && !cfg_we;
	assign in_fire   = req.valid && req.ready;
	assign rd_fire   = in_fire && (req.data.req_type == REQ_READ);

	assign end_x    = (FIT_W+1)'(offset_x_q) + (FIT_W+1)'(fit_width_q);
	assign end_y    = (FIT_W+1)'(offset_y_q) + (FIT_W+1)'(fit_height_q);
	assign frame_in = ((FIT_W+1)'(req.data.out_col) < (FIT_W+1)'(THUMB_SIZE))
		&& ((FIT_W+1)'(req.data.out_row) < (FIT_W+1)'(THUMB_SIZE))
		&& (req.data.out_col >= offset_x_q)
		&& ((FIT_W+1)'(req.data.out_col) < end_x)
		&& (req.data.out_row >= offset_y_q)
		&& ((FIT_W+1)'(req.data.out_row) < end_y);

	assign div_shift = {div_rem_q, div_num_q[DIV_N_W-1]};
	assign div_ge    = div_shift >= {1'b0, div_den_q};

	always_comb begin
		if (div_quo_q == '0)
			short_c = FIT_W'(1);
		else if (div_quo_q > DIV_N_W'(THUMB_SIZE))
			short_c = FIT_W'(THUMB_SIZE);
		else
			short_c = div_quo_q[FIT_W-1:0];
	end

	assign samp_dim = (state_q == S_Y_SET) ? w_c : h_c;
	always_comb begin
		if (div_quo_q > DIV_N_W'(samp_dim - DIM_W'(1)))
			samp_c = samp_dim - DIM_W'(1);
		else
			samp_c = div_quo_q[DIM_W-1:0];
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_d   = state_q;
		div_load  = 1'b0;
		div_num_d = '0;
		div_den_d = '0;
		unique case (state_q)
			S_IDLE: begin
				if (refit_q && !cfg_we) begin
					div_load = 1'b1;
					if (wide) begin
						div_num_d = (DIV_N_W'(h_c) << (COORD_W + 1)) + DIV_N_W'(w_c);
						div_den_d = DIV_D_W'(w_c) << 1;
					end else begin
						div_num_d = (DIV_N_W'(w_c) << (COORD_W + 1)) + DIV_N_W'(h_c);
						div_den_d = DIV_D_W'(h_c) << 1;
					end
					state_d = S_FIT_DIV;
				end else if (rd_fire) begin
					state_d = frame_in ? S_X_SET : S_OUT;
				end
			end
			S_FIT_DIV: if (div_cnt_q == DIV_CNT_W'(1)) state_d = S_FIT_END;
			S_FIT_END: state_d = S_IDLE;
			S_X_SET: begin
				div_load  = 1'b1;
				div_num_d = DIV_N_W'({dx_q, 1'b1}) * DIV_N_W'(w_c);
				div_den_d = DIV_D_W'(fit_width_q) << 1;
				state_d   = S_X_DIV;
			end
			S_X_DIV: if (div_cnt_q == DIV_CNT_W'(1)) state_d = S_Y_SET;
			S_Y_SET: begin
				div_load  = 1'b1;
				div_num_d = DIV_N_W'({dy_q, 1'b1}) * DIV_N_W'(h_c);
				div_den_d = DIV_D_W'(fit_height_q) << 1;
				state_d   = S_Y_DIV;
			end
			S_Y_DIV: if (div_cnt_q == DIV_CNT_W'(1)) state_d = S_ADDR;
			S_ADDR: state_d = S_READ;
			S_READ: state_d = S_OUT;
			S_OUT: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			src_width_q  <= DIM_W'(512);
			src_height_q <= DIM_W'(512);
			refit_q      <= 1'b1;
			fit_width_q  <= FIT_W'(THUMB_SIZE);
			fit_height_q <= FIT_W'(THUMB_SIZE);
			offset_x_q   <= '0;
			offset_y_q   <= '0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && refit_q && !cfg_we)
				refit_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SRC_WIDTH:  src_width_q  <= cfg_data;
					REG_SRC_HEIGHT: src_height_q <= cfg_data;
					default: ;
				endcase
				refit_q <= 1'b1;
			end
			if (state_q == S_FIT_END) begin
				if (wide) begin
					fit_width_q  <= FIT_W'(THUMB_SIZE);
					fit_height_q <= short_c;
					offset_x_q   <= '0;
					offset_y_q   <= OFF_W'((FIT_W'(THUMB_SIZE) - short_c) >> 1);
				end else begin
					fit_height_q <= FIT_W'(THUMB_SIZE);
					fit_width_q  <= short_c;
					offset_y_q   <= '0;
					offset_x_q   <= OFF_W'((FIT_W'(THUMB_SIZE) - short_c) >> 1);
				end
			end
			if (div_load)
				div_cnt_q <= DIV_CNT_W'(DIV_N_W);
			else if (div_cnt_q != '0)
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// bit-serial restoring divider and read datapath
	always_ff @(posedge clk) begin
		if (div_load) begin
			div_num_q <= div_num_d;
			div_den_q <= div_den_d;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end else if (div_cnt_q != '0) begin
			div_num_q <= div_num_q << 1;
			div_rem_q <= div_ge ? DIV_D_W'(div_shift - {1'b0, div_den_q})
			                    : div_shift[DIV_D_W-1:0];
			div_quo_q <= {div_quo_q[DIV_N_W-2:0], div_ge};
		end
		if (rd_fire && state_q == S_IDLE) begin
			bg_q <= !frame_in;
			dx_q <= req.data.out_col - offset_x_q;
			dy_q <= req.data.out_row - offset_y_q;
		end
		if (state_q == S_Y_SET)
			sx_q <= samp_c;
		if (state_q == S_ADDR)
			addr_s <= FULL_ADDR_W'(samp_c) * FULL_ADDR_W'(w_c) + FULL_ADDR_W'(sx_q);
		if (state_q == S_READ)
			oob_q <= addr_s >= FULL_ADDR_W'(SRC_DEPTH);
		if (out_load) begin
			if (bg_q) begin
				out_q.thumb_red   <= BG_RED;
				out_q.thumb_green <= BG_GREEN;
				out_q.thumb_blue  <= BG_BLUE;
				out_q.thumb_alpha <= BG_ALPHA;
				out_q.in_image    <= 1'b0;
			end else begin
				out_q.thumb_red   <= oob_q ? 8'd0 : rd_data_s[7:0];
				out_q.thumb_green <= oob_q ? 8'd0 : rd_data_s[15:8];
				out_q.thumb_blue  <= oob_q ? 8'd0 : rd_data_s[23:16];
				out_q.thumb_alpha <= oob_q ? 8'd0 : rd_data_s[31:24];
				out_q.in_image    <= 1'b1;
			end
		end
	end

	// source pixel memory
	always_ff @(posedge clk) begin
		if (in_fire && req.data.req_type == REQ_LOAD &&
		    (ADDR_W+1)'(req.data.src_index) < (ADDR_W+1)'(SRC_DEPTH))
			mem_q[req.data.src_index[ADDR_W-1:0]] <= {req.data.pix_alpha, req.data.pix_blue,
			                                         req.data.pix_green, req.data.pix_red};
		if (state_q == S_READ)
			rd_data_s <= mem_q[addr_s[ADDR_W-1:0]];
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

[dv/tb_letterbox_nearest_scaler.sv]
module tb_letterbox_nearest_scaler;
	timeunit 1ns;
	timeprecision 1ps;
	import lns_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 80;

	class thumb_scoreboard;
		bit [31:0] pixels [SRC_DEPTH];
		bit loaded [SRC_DEPTH];
		int unsigned width_reg = 512;
		int unsigned height_reg = 512;
		int unsigned w, h, fit_w, fit_h, off_x, off_y;
		lns_out_t expected [$];
		int errors = 0;

		function int unsigned sane_dim(int unsigned v);
			if (v == 0) return 1;
			if (v > MAX_SRC_DIM) return MAX_SRC_DIM;
			return v;
		endfunction

		function int unsigned short_fit(int unsigned s, int unsigned l);
			longint unsigned v;
			v = (2 * longint'(THUMB_SIZE) * s + l) / (2 * longint'(l));
			if (v < 1) v = 1;
			if (v > THUMB_SIZE) v = THUMB_SIZE;
			return int'(v);
		endfunction

		function void refit();
			w = sane_dim(width_reg);
			h = sane_dim(height_reg);
			if (w >= h) begin
				fit_w = THUMB_SIZE;
				fit_h = short_fit(h, w);
			end else begin
				fit_h = THUMB_SIZE;
				fit_w = short_fit(w, h);
			end
			off_x = (THUMB_SIZE - fit_w) / 2;
			off_y = (THUMB_SIZE - fit_h) / 2;
		endfunction

		function new();
			refit();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
			if (idx == REG_SRC_WIDTH)
				width_reg = val & 'h1FFF;
			else if (idx == REG_SRC_HEIGHT)
				height_reg = val & 'h1FFF;
			refit();
		endfunction

		function int unsigned nearest(int unsigned pos, int unsigned dim, int unsigned fit);
			longint unsigned v;
			v = ((2 * longint'(pos) + 1) * dim) / (2 * longint'(fit));
			if (v > dim - 1) v = dim - 1;
			return int'(v);
		endfunction

		// -1 for background, else the flat source address
		function longint source_addr(int unsigned col, int unsigned row);
			if (col >= THUMB_SIZE || row >= THUMB_SIZE || col < off_x ||
			    col >= off_x + fit_w || row < off_y || row >= off_y + fit_h)
				return -1;
			return longint'(nearest(row - off_y, h, fit_h)) * w +
			       nearest(col - off_x, w, fit_w);
		endfunction

		function void note_beat(lns_in_t b);
			lns_out_t r;
			longint a;
			bit [31:0] px;
			if (b.req_type == REQ_LOAD) begin
				pixels[b.src_index] = {b.pix_alpha, b.pix_blue, b.pix_green, b.pix_red};
				loaded[b.src_index] = 1;
				return;
			end
			a = source_addr(b.out_col, b.out_row);
			if (a < 0) begin
				r = '{BG_RED, BG_GREEN, BG_BLUE, BG_ALPHA, 1'b0};
			end else begin
				px = (a < SRC_DEPTH) ? pixels[a] : 32'd0;
				r = '{px[7:0], px[15:8], px[23:16], px[31:24], 1'b1};
			end
			expected.push_back(r);
		endfunction

		function void check_result(lns_out_t got);
			lns_out_t want;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: %h", got);
				return;
			end
			want = expected.pop_front();
			if (got.thumb_red !== want.thumb_red || got.thumb_green !== want.thumb_green ||
			    got.thumb_blue !== want.thumb_blue || got.thumb_alpha !== want.thumb_alpha ||
			    got.in_image !== want.in_image) begin
				errors++;
				if (errors <= 10)
					$display("result mismatch: expected r%0d g%0d b%0d a%0d in%0d, got r%0d g%0d b%0d a%0d in%0d",
						want.thumb_red, want.thumb_green, want.thumb_blue, want.thumb_alpha,
						want.in_image, got.thumb_red, got.thumb_green, got.thumb_blue,
						got.thumb_alpha, got.in_image);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycles = 0;
	thumb_scoreboard sb = new();

	lns_in_if req_if();
	lns_out_if rsp_if();

	letterbox_nearest_scaler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result(rsp_if.data);
	end

	task automatic send_beat(lns_in_t b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid = 0;
			@(negedge clk);
		end
		req_if.valid = 1;
		req_if.data = b;
		do @(posedge clk); while (!req_if.ready);
		sb.note_beat(b);
	endtask

	task automatic load_pixel(int unsigned idx);
		lns_in_t b;
		b = '0;
		b.req_type = REQ_LOAD;
		b.src_index = 16'(idx);
		b.pix_red = 8'($urandom);
		b.pix_green = 8'($urandom);
		b.pix_blue = 8'($urandom);
		b.pix_alpha = 8'($urandom);
		send_beat(b);
	endtask

	// never sample an entry that was not loaded
	task automatic read_pixel(int unsigned col, int unsigned row);
		lns_in_t b;
		longint a;
		a = sb.source_addr(col, row);
		if (a >= 0 && a < SRC_DEPTH && !sb.loaded[a])
			load_pixel(32'(a));
		b = '0;
		b.req_type = REQ_READ;
		b.src_index = 16'($urandom);
		b.pix_red = 8'($urandom);
		b.out_col = 9'(col);
		b.out_row = 9'(row);
		send_beat(b);
	endtask

	task automatic drain();
		@(negedge clk);
		req_if.valid = 0;
		while (sb.expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = DIM_W'(val);
		@(negedge clk);
		cfg_we = 0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_size(int unsigned wv, int unsigned hv);
		write_reg(REG_SRC_WIDTH, wv);
		write_reg(REG_SRC_HEIGHT, hv);
	endtask

	task automatic random_beats(int n);
		int unsigned span;
		lns_in_t b;
		span = sb.w * sb.h;
		if (span > SRC_DEPTH) span = SRC_DEPTH;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1: load_pixel($urandom_range(span - 1));
				2: load_pixel($urandom_range(SRC_DEPTH - 1));
				3: begin
					// picture edges
					read_pixel(sb.off_x + ($urandom_range(1) ? sb.fit_w - 1 : 0),
						$urandom_range(THUMB_SIZE - 1));
				end
				default: read_pixel($urandom_range(THUMB_SIZE - 1),
					$urandom_range(THUMB_SIZE - 1));
			endcase
		end
	endtask

	initial begin
		int unsigned widths [12] = '{512, 0, 4096, 1, 8191, 300, 7, 100, 255, 64, 0, 0};
		int unsigned heights [12] = '{512, 0, 1, 4096, 8191, 200, 13, 655, 256, 48, 0, 0};
		lns_in_t b;
		req_if.valid = 0;
		req_if.data = '0;
		rsp_if.ready = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: byte extremes, corners, store end
		b = '0;
		b.req_type = REQ_LOAD;
		send_beat(b);
		b.src_index = 16'hFFFF;
		b.pix_red = 8'hFF;
		b.pix_green = 8'hFF;
		b.pix_blue = 8'hFF;
		b.pix_alpha = 8'hFF;
		send_beat(b);
		read_pixel(0, 0);
		read_pixel(511, 511);
		read_pixel(511, 0);
		read_pixel(0, 127);
		drain();
		set_size(4096, 1);
		read_pixel(0, 255);
		read_pixel(511, 255);
		read_pixel(0, 0);
		read_pixel(0, 256);
		drain();
		set_size(1, 4096);
		read_pixel(255, 0);
		read_pixel(256, 511);
		read_pixel(254, 100);
		drain();
		set_size(0, 0);
		read_pixel(300, 300);
		drain();
		set_size(8191, 8191);
		read_pixel(0, 0);
		read_pixel(511, 511);
		read_pixel(200, 3);

		widths[10] = $urandom_range(1, 300);
		heights[10] = $urandom_range(1, 300);
		widths[11] = $urandom_range(1, 8191);
		heights[11] = $urandom_range(1, 8191);
		for (int p = 0; p < 12; p++) begin
			drain();
			set_size(widths[p], heights[p]);
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 74; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 74; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			random_beats(75);
		end
		drain();

		if (sb.errors == 0 && sb.expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
